// ===== rtl/delimited_frame_deframer_assert.svh =====
// Assertion macros used by the checker file of the deframer.
`ifndef DELIMITED_FRAME_DEFRAMER_ASSERT_SVH
`define DELIMITED_FRAME_DEFRAMER_ASSERT_SVH

// Concurrent assertion sampled on the clock and switched off during reset.
`define DFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Concurrent assertion sampled on the clock that also holds during reset.
`define DFD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/dfd_pkg.sv =====
// Shared types and constants of the delimited frame deframer.
package dfd_pkg;

   localparam int DEFAULT_FRAME_BYTES = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam int COUNT_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_COUNT = 2'd3;

   localparam logic [7:0] START_BYTE_RESET = 8'hAA;
   localparam logic [7:0] END_BYTE_RESET = 8'h55;
   localparam logic [COUNT_W-1:0] START_COUNT_RESET = 3'd1;
   localparam logic [COUNT_W-1:0] END_COUNT_RESET = 3'd1;

   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_MISMATCH = 2'd1;
   localparam logic [1:0] KIND_NO_BUFFER = 2'd2;

   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_FRAME = 2'd1,
      OP_DROP = 2'd2
   } op_type;

   typedef struct packed {
      op_type op;
      logic [7:0] data;
      logic [1:0] kind;
   } cmd_type;

endpackage

// ===== rtl/dfd_front.sv =====
// Front end: configuration registers and the delimiter parser that issues commands.
module dfd_front #(
   parameter int FRAME_BYTES = dfd_pkg::DEFAULT_FRAME_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          req_chunk_end,
   input  logic                          req_buffer_free,
   input  logic                          csr_we,
   input  logic [dfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dfd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                          q_full,
   output logic                          q_push,
   output dfd_pkg::cmd_type              q_cmd
);
   import dfd_pkg::*;

   localparam int CntW = $clog2(FRAME_BYTES + 1);

   typedef enum logic [4:0] {
      PH_HUNT = 5'b00001,
      PH_START = 5'b00010,
      PH_DATA = 5'b00100,
      PH_END = 5'b01000,
      PH_DROP = 5'b10000
   } phase_type;

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] r;
      if (c == 3'd0) begin
         r = 3'd1;
      end else if (c > 3'd4) begin
         r = 3'd4;
      end else begin
         r = c;
      end
      return r;
   endfunction

   logic [7:0] start_byte_ff, start_byte_in;
   logic [7:0] end_byte_ff, end_byte_in;
   logic [COUNT_W-1:0] start_count_ff, start_count_in;
   logic [COUNT_W-1:0] end_count_ff, end_count_in;
   phase_type phase_ff, phase_in;
   logic [CntW-1:0] rem_ff, rem_in;

   logic accept;
   logic [COUNT_W-1:0] sc;
   logic [COUNT_W-1:0] ec;
   logic [CntW-1:0] data_len;
   logic [CntW-1:0] rem_dec;

   assign req_full = q_full;
   assign accept = req_push && !q_full;
   assign sc = clamp_count(start_count_ff);
   assign ec = clamp_count(end_count_ff);
   assign data_len = CntW'(FRAME_BYTES) - CntW'(sc) - CntW'(ec);
   assign rem_dec = rem_ff - CntW'(1);

   always_comb begin
      start_byte_in = start_byte_ff;
      end_byte_in = end_byte_ff;
      start_count_in = start_count_ff;
      end_count_in = end_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_BYTE: start_byte_in = csr_wdata;
            CSR_END_BYTE: end_byte_in = csr_wdata;
            CSR_START_COUNT: start_count_in = csr_wdata[COUNT_W-1:0];
            CSR_END_COUNT: end_count_in = csr_wdata[COUNT_W-1:0];
            default: start_byte_in = start_byte_ff;
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      rem_in = rem_ff;
      q_push = 1'b0;
      q_cmd.op = OP_STORE;
      q_cmd.data = req_rx_byte;
      q_cmd.kind = KIND_FRAME;
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == start_byte_ff) begin
                  q_push = 1'b1;
                  if (!req_buffer_free) begin
                     q_cmd.op = OP_DROP;
                     q_cmd.kind = KIND_NO_BUFFER;
                     phase_in = req_chunk_end ? PH_HUNT : PH_DROP;
                     rem_in = '0;
                  end else begin
                     phase_in = PH_START;
                     rem_in = CntW'(sc - 3'd1);
                  end
               end
            end
            PH_START: begin
               q_push = 1'b1;
               if (req_rx_byte != start_byte_ff) begin
                  q_cmd.op = OP_DROP;
                  q_cmd.kind = KIND_MISMATCH;
                  phase_in = req_chunk_end ? PH_HUNT : PH_DROP;
                  rem_in = '0;
               end else begin
                  rem_in = rem_dec;
               end
            end
            PH_DATA: begin
               q_push = 1'b1;
               rem_in = rem_dec;
            end
            PH_END: begin
               q_push = 1'b1;
               if (req_rx_byte != end_byte_ff) begin
                  q_cmd.op = OP_DROP;
                  q_cmd.kind = KIND_MISMATCH;
                  phase_in = req_chunk_end ? PH_HUNT : PH_DROP;
                  rem_in = '0;
               end else if (rem_dec == '0) begin
                  q_cmd.op = OP_FRAME;
                  phase_in = PH_HUNT;
                  rem_in = '0;
               end else begin
                  rem_in = rem_dec;
               end
            end
            PH_DROP: begin
               if (req_chunk_end) begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               rem_in = '0;
            end
         endcase
      end
      // A phase with nothing left to receive passes straight on to the next one.
      if (phase_in == PH_START && rem_in == '0) begin
         phase_in = PH_DATA;
         rem_in = data_len;
      end
      if (phase_in == PH_DATA && rem_in == '0) begin
         phase_in = PH_END;
         rem_in = CntW'(ec);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         end_byte_ff <= END_BYTE_RESET;
         start_count_ff <= START_COUNT_RESET;
         end_count_ff <= END_COUNT_RESET;
         phase_ff <= PH_HUNT;
         rem_ff <= '0;
      end else begin
         start_byte_ff <= start_byte_in;
         end_byte_ff <= end_byte_in;
         start_count_ff <= start_count_in;
         end_count_ff <= end_count_in;
         phase_ff <= phase_in;
         rem_ff <= rem_in;
      end
   end

endmodule

// ===== rtl/dfd_cmd_queue.sv =====
// Short command queue between the parser and the frame buffer back end.
module dfd_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dfd_pkg::cmd_type wdata,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output dfd_pkg::cmd_type rdata
);
   import dfd_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CountW = $clog2(QUEUE_DEPTH + 1);

   cmd_type entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign full = count_ff == CountW'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign rdata = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/dfd_back.sv =====
// Back end: frame buffer memory, frame drain and the result register.
module dfd_back #(
   parameter int FRAME_BYTES = dfd_pkg::DEFAULT_FRAME_BYTES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  dfd_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last
);
   import dfd_pkg::*;

   localparam int IdxW = $clog2(FRAME_BYTES);

   logic [7:0] mem [FRAME_BYTES];

   logic drain_ff, drain_in;
   logic [IdxW-1:0] rd_idx_ff, rd_idx_in;
   logic [IdxW-1:0] wr_idx_ff, wr_idx_in;
   logic rd_pend_ff;
   logic rd_last_ff;
   logic [7:0] rd_data_ff;
   logic out_valid_ff, out_valid_in;
   logic [1:0] out_kind_ff;
   logic [7:0] out_byte_ff;
   logic out_last_ff;

   logic out_free;
   logic mem_we;
   logic rd_issue;
   logic rd_last;
   logic drop_load;

   assign out_free = !out_valid_ff || rsp_pop;
   assign cmd_pop = cmd_valid && !drain_ff &&
                    (cmd.op != OP_DROP || (!rd_pend_ff && out_free));
   assign mem_we = cmd_pop && cmd.op != OP_DROP;
   assign drop_load = cmd_pop && cmd.op == OP_DROP;
   assign rd_issue = drain_ff && !rd_pend_ff && out_free;
   assign rd_last = rd_idx_ff == IdxW'(FRAME_BYTES - 1);

   assign rsp_empty = !out_valid_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_last = out_last_ff;

   always_comb begin
      drain_in = drain_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      out_valid_in = out_valid_ff;
      if (cmd_pop && cmd.op == OP_FRAME) begin
         drain_in = 1'b1;
      end else if (rd_issue && rd_last) begin
         drain_in = 1'b0;
      end
      if (rd_issue) begin
         rd_idx_in = rd_last ? '0 : rd_idx_ff + IdxW'(1);
      end
      if (cmd_pop) begin
         case (cmd.op)
            OP_STORE: wr_idx_in = wr_idx_ff + IdxW'(1);
            OP_FRAME: wr_idx_in = '0;
            OP_DROP: wr_idx_in = '0;
            default: wr_idx_in = wr_idx_ff;
         endcase
      end
      if (rd_pend_ff || drop_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff <= 1'b0;
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         rd_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         drain_ff <= drain_in;
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         rd_pend_ff <= rd_issue;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx_ff] <= cmd.data;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[rd_idx_ff];
         rd_last_ff <= rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         out_kind_ff <= KIND_FRAME;
         out_byte_ff <= rd_data_ff;
         out_last_ff <= rd_last_ff;
      end else if (drop_load) begin
         out_kind_ff <= cmd.kind;
         out_byte_ff <= '0;
         out_last_ff <= 1'b1;
      end
   end

endmodule

// ===== rtl/delimited_frame_deframer.sv =====
// Delimited frame deframer: the top level joining parser, command queue and back end.
// The parser takes one received byte per clock while its four-entry command queue has room and
// issues at most one command per byte. The back end writes each stored byte into the frame
// buffer. A completed frame is read out of the single-port frame buffer through a registered
// memory read, then the result register; a read starts only when no read is pending and the
// result register is free, and no command is taken while a frame drains. A drop produces one
// result once the result register is free. req_full rises when commands pile up in the queue,
// while a frame drains or while a drop waits for the receiver to take the result ahead of it.
module delimited_frame_deframer #(
   parameter int FRAME_BYTES = dfd_pkg::DEFAULT_FRAME_BYTES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [7:0]                     req_rx_byte,
   input  logic                           req_chunk_end,
   input  logic                           req_buffer_free,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [1:0]                     rsp_kind,
   output logic [7:0]                     rsp_frame_byte,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic [dfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dfd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dfd_pkg::*;

   logic q_full;
   logic q_push;
   cmd_type q_wdata;
   logic q_pop;
   logic q_empty;
   cmd_type q_rdata;

   dfd_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_rx_byte(req_rx_byte),
      .req_chunk_end(req_chunk_end),
      .req_buffer_free(req_buffer_free),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .q_full(q_full),
      .q_push(q_push),
      .q_cmd(q_wdata)
   );

   dfd_cmd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .wdata(q_wdata),
      .full(q_full),
      .pop(q_pop),
      .empty(q_empty),
      .rdata(q_rdata)
   );

   dfd_back #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(!q_empty),
      .cmd(q_rdata),
      .cmd_pop(q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_kind(rsp_kind),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_last(rsp_last)
   );

endmodule

// ===== rtl/dfd_checker.sv =====
// Port-level checker for the deframer and its bind to the top level.
`include "delimited_frame_deframer_assert.svh"

module dfd_checker #(
   parameter int FRAME_BYTES = dfd_pkg::DEFAULT_FRAME_BYTES
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_full,
   input logic                           rsp_empty,
   input logic                           rsp_pop,
   input logic [1:0]                     rsp_kind,
   input logic [7:0]                     rsp_frame_byte,
   input logic                           rsp_last
);
   import dfd_pkg::*;

   localparam int CntW = $clog2(FRAME_BYTES + 1);

   logic [CntW-1:0] cnt_ff, cnt_in;
   logic frame_taken;

   assign frame_taken = rsp_pop && !rsp_empty && rsp_kind == KIND_FRAME;

   always_comb begin
      cnt_in = cnt_ff;
      if (frame_taken) begin
         cnt_in = rsp_last ? '0 : cnt_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Results are gone and the input side is open right after reset.
   `DFD_ASSERT_ALWAYS(a_reset_clear, reset |=> (rsp_empty && !req_full),
      "not idle after reset")
   `DFD_ASSERT(a_drop_form,
      (!rsp_empty && rsp_kind != KIND_FRAME) |-> (rsp_last && rsp_frame_byte == 8'd0),
      "malformed drop result")
   `DFD_ASSERT(a_frame_length,
      (frame_taken && rsp_last) |-> (cnt_ff == CntW'(FRAME_BYTES - 1)),
      "frame of wrong length")
   `DFD_ASSERT(a_hold,
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_kind) &&
         $stable(rsp_frame_byte) && $stable(rsp_last)),
      "stalled result changed")

endmodule

bind delimited_frame_deframer dfd_checker #(.FRAME_BYTES(FRAME_BYTES)) u_checker (.*);
